>>> rtl/gstd_pkg.sv
// Package for the group-serialized task dispatcher.
// Holds the word types, command and status codes, and controller/datapath links.
// No dependencies.
package gstd_pkg;

  localparam int unsigned TagW   = 16;
  localparam int unsigned GroupW = 16;

  localparam logic [GroupW-1:0] FirstGroup = GroupW'(1);
  localparam logic [GroupW-1:0] LastGroup  = '1;

  typedef enum logic [1:0] {
    CMD_ENQUEUE   = 2'd0,
    CMD_FETCH     = 2'd1,
    CMD_RELEASE   = 2'd2,
    CMD_NEW_GROUP = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NONE   = 2'd1,
    ST_FULL   = 2'd2,
    ST_REJECT = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [GroupW-1:0] group_id;
    logic [TagW-1:0]   task_tag;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [TagW-1:0]   out_task;
    logic [GroupW-1:0] out_group;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_CHK,
    S_SHIFT_WR,
    S_RESP
  } ctl_state_e;

  typedef struct packed {
    logic    load_req;
    logic    enq_write;
    logic    set_status;
    status_e status;
    logic    rd_issue;
    logic    rd_next;
    logic    take_hit;
    logic    idx_inc;
    logic    shift_write;
    logic    count_dec;
    logic    release_grp;
    logic    new_group;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic tag_zero;
    logic full;
    logic empty;
    logic eligible;
    logic at_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/gstd_ctrl.sv
// Controller state machine of the task dispatcher.
// Sequences enqueue, fetch scan and compaction, release and new-group.
// Depends on gstd_pkg.
module gstd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gstd_pkg::dp_stat_t stat_i,
  output gstd_pkg::dp_cmd_t  cmd_o
);
  import gstd_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_RESP;
        unique case (stat_i.cmd)
          CMD_ENQUEUE: begin
            if (stat_i.tag_zero) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_REJECT;
            end else if (stat_i.full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_FULL;
            end else begin
              cmd_o.enq_write = 1'b1;
            end
          end
          CMD_FETCH: begin
            if (stat_i.empty) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_NONE;
            end else begin
              state_d = S_SCAN_RD;
            end
          end
          CMD_RELEASE:   cmd_o.release_grp = 1'b1;
          CMD_NEW_GROUP: cmd_o.new_group   = 1'b1;
          default:       state_d = S_RESP;
        endcase
      end
      S_SCAN_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (stat_i.eligible) begin
          cmd_o.take_hit = 1'b1;
          state_d        = S_SHIFT_CHK;
        end else if (stat_i.at_last) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_NONE;
          state_d          = S_RESP;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SCAN_RD;
        end
      end
      S_SHIFT_CHK: begin
        if (stat_i.at_last) begin
          cmd_o.count_dec = 1'b1;
          state_d         = S_RESP;
        end else begin
          cmd_o.rd_issue = 1'b1;
          cmd_o.rd_next  = 1'b1;
          state_d        = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.shift_write = 1'b1;
        cmd_o.idx_inc     = 1'b1;
        state_d           = S_SHIFT_CHK;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> rtl/gstd_dp.sv
// Datapath of the task dispatcher: pending queue memory, busy group set,
// group id counter and result register. Depends on gstd_pkg.
module gstd_dp #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned BUSY_DEPTH  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gstd_pkg::in_word_t  in_word_i,
  input  gstd_pkg::dp_cmd_t   cmd_i,
  output gstd_pkg::dp_stat_t  stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gstd_pkg::out_word_t out_word_o
);
  import gstd_pkg::*;

  localparam int unsigned QW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = (BUSY_DEPTH > 1) ? $clog2(BUSY_DEPTH) : 1;
  localparam logic [CW-1:0] Depth = CW'(QUEUE_DEPTH);

  typedef struct packed {
    logic [TagW-1:0]   tag;
    logic [GroupW-1:0] group;
  } entry_t;

  in_word_t          req_q;
  logic [CW-1:0]     idx_q, count_q;
  logic [CW-1:0]     idx_next;
  entry_t            mem_q [QUEUE_DEPTH];
  entry_t            rd_data_q;
  entry_t            wr_data;
  logic [QW-1:0]     rd_addr, wr_addr;
  logic              wr_en;
  logic [GroupW-1:0] busy_grp_q [BUSY_DEPTH];
  logic [BUSY_DEPTH-1:0] busy_vld_q;
  logic [BUSY_DEPTH-1:0] hit_vec, rel_vec;
  logic [SW-1:0]     free_slot;
  logic              slot_found;
  logic              eligible;
  logic [GroupW-1:0] next_grp_q;
  out_word_t         pend_q, out_q;
  logic              out_valid_q;
  logic              out_free;

  assign idx_next = idx_q + CW'(1);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    free_slot = '0;
    for (int s = BUSY_DEPTH - 1; s >= 0; s--) begin
      hit_vec[s] = busy_vld_q[s] && (busy_grp_q[s] == rd_data_q.group);
      rel_vec[s] = busy_vld_q[s] && (busy_grp_q[s] == req_q.group_id);
      if (!busy_vld_q[s]) begin
        free_slot = SW'(s);
      end
    end
  end

  assign slot_found = !(&busy_vld_q);
  assign eligible   = (rd_data_q.group == '0) || (slot_found && !(|hit_vec));

  assign stat_o.cmd      = cmd_e'(req_q.command);
  assign stat_o.tag_zero = (req_q.task_tag == '0);
  assign stat_o.full     = (count_q == Depth);
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.eligible = eligible;
  assign stat_o.at_last  = (idx_next == count_q);
  assign stat_o.out_free = out_free;

  assign rd_addr       = cmd_i.rd_next ? idx_next[QW-1:0] : idx_q[QW-1:0];
  assign wr_en         = cmd_i.enq_write || cmd_i.shift_write;
  assign wr_addr       = cmd_i.enq_write ? count_q[QW-1:0] : idx_q[QW-1:0];
  assign wr_data.tag   = cmd_i.enq_write ? req_q.task_tag : rd_data_q.tag;
  assign wr_data.group = cmd_i.enq_write ? req_q.group_id : rd_data_q.group;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_word_i;
    end
    if (cmd_i.take_hit && rd_data_q.group != '0) begin
      busy_grp_q[free_slot] <= rd_data_q.group;
    end
    if (cmd_i.load_req) begin
      pend_q <= '0;
    end else begin
      if (cmd_i.set_status) begin
        pend_q.status <= cmd_i.status;
      end
      if (cmd_i.take_hit) begin
        pend_q.out_task  <= rd_data_q.tag;
        pend_q.out_group <= rd_data_q.group;
      end
      if (cmd_i.new_group) begin
        pend_q.out_group <= next_grp_q;
      end
    end
    if (cmd_i.out_load) begin
      out_q <= pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      count_q     <= '0;
      busy_vld_q  <= '0;
      next_grp_q  <= FirstGroup;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_req) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_next;
      end
      if (cmd_i.enq_write) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.count_dec) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.release_grp && req_q.group_id != '0) begin
        busy_vld_q <= busy_vld_q & ~rel_vec;
      end else if (cmd_i.take_hit && rd_data_q.group != '0) begin
        busy_vld_q[free_slot] <= 1'b1;
      end
      if (cmd_i.new_group) begin
        next_grp_q <= (next_grp_q == LastGroup) ? FirstGroup : next_grp_q + GroupW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Depth)
    else $error("pending count beyond queue depth");

  a_enq_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.enq_write |=> count_q == $past(count_q) + CW'(1))
    else $error("enqueue did not grow the queue");

  a_hit_marks_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take_hit && rd_data_q.group != '0) |=>
      $countones(busy_vld_q) == $countones($past(busy_vld_q)) + 1)
    else $error("grouped fetch did not claim a busy slot");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while held");

  a_group_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_grp_q != '0)
    else $error("group id counter reached zero");

endmodule

>>> rtl/group_serialized_task_dispatch.sv
// Top level of the group-serialized task dispatcher: controller plus datapath.
// Depends on gstd_pkg, gstd_ctrl and gstd_dp.
//
//   channel  handshake                 word        direction
//   in       in_valid_i / in_ready_o   in_word_i   command in
//   out      out_valid_o / out_ready_i out_word_o  result out
//
// Enqueue, release, new-group and fetch on an empty queue pass through a dispatch step
// and a response step. Fetch otherwise adds a read step and a check step per entry
// scanned, then on a hit a check step and a write step per entry moved up and a final
// check step. One command at a time; the next can be accepted in the same cycle that the
// result turns valid. A held result does not block acceptance of the next command; a
// stalled output only holds the following command in its response step.
// Reset clears the queue count, busy marks and output valid; next group id is 1.
module group_serialized_task_dispatch #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned BUSY_DEPTH  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gstd_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gstd_pkg::out_word_t out_word_o
);
  import gstd_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  gstd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  gstd_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .BUSY_DEPTH  (BUSY_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
